// ===== src/ttod_pkg.sv =====
// ============================================================================
// Tick time-of-day counter package
// Shared constants and opcodes for the tick time-of-day counter.
// ============================================================================
`default_nettype none

package ttod_pkg;

    localparam int unsigned MS_W     = 27;
    localparam int unsigned DAY_W    = 16;
    localparam int unsigned STEP_W   = 8;
    localparam int unsigned WAIT_W   = 16;
    localparam int unsigned SINCE_W  = 9;
    localparam int unsigned GAP_W    = MS_W + 2;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 48;

    localparam logic [MS_W-1:0]    MS_PER_DAY    = 27'd86400000;
    localparam logic [SINCE_W-1:0] DECISEC_MS    = 9'd100;
    localparam logic [STEP_W-1:0]  MSEC_PER_TICK_RESET = 8'd1;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

endpackage

`default_nettype wire

// ===== src/tick_time_of_day_counter.sv =====
// ============================================================================
// Tick time-of-day counter
// Keeps milliseconds of the day and a day count, driven by tick and query
// words, and answers each word with a time snapshot.
// ============================================================================
// Usage:
// Input words arrive on the s_ group. s_tuser carries the opcode (tick or
// elapsed-time query) and s_tdata carries the query start time and wait.
// Every input word produces exactly one output word on the m_ group with
// the millisecond of the day, the day number, the decisecond pulse flag and
// the query result flag.
// An accepted word is held in an input register, processed by combinational
// logic against the time state, and placed in the output register; one word
// is accepted in every cycle while the output is not stalled.
// When the receiver stalls, the output word holds and the input register
// still takes one more word; s_tready falls only while both are full.
// The milliseconds-per-tick register is written through cfg_wr_en and
// cfg_wr_data, by the user only while the block is idle; it is not enforced.
// Reset clears the time of day, the day count and the decisecond distance,
// sets milliseconds per tick to one and empties both registers.
`default_nettype none

module tick_time_of_day_counter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ttod_pkg::STEP_W-1:0]   cfg_wr_data,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // start_time [26:0], wait_msec [42:27], zero [47:43]
    input  wire logic [ttod_pkg::S_DATA_W-1:0] s_tdata,
    // opcode [0]
    input  wire logic                          s_tuser,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // milliseconds [26:0], day_number [42:27], decisec_pulse [43],
    // passed [44], zero [47:45]
    output      logic [ttod_pkg::M_DATA_W-1:0] m_tdata
);

    import ttod_pkg::*;

    logic                 in_valid_reg;
    logic                 op_reg;
    logic [MS_W-1:0]      start_reg;
    logic [WAIT_W-1:0]    wait_reg;

    logic                 out_valid_reg;
    logic [MS_W-1:0]      out_ms_reg;
    logic [DAY_W-1:0]     out_day_reg;
    logic                 out_pulse_reg;
    logic                 out_passed_reg;

    logic [MS_W-1:0]      ms_reg;
    logic [MS_W-1:0]      ms_next;
    logic [DAY_W-1:0]     day_reg;
    logic [DAY_W-1:0]     day_next;
    logic [SINCE_W-1:0]   since_reg;
    logic [SINCE_W-1:0]   since_next;
    logic [STEP_W-1:0]    step_reg;

    logic                 advance;
    logic                 in_take;
    logic [MS_W:0]        ms_sum;
    logic [SINCE_W-1:0]   since_sum;
    logic                 pulse;
    logic signed [GAP_W-1:0] gap;
    logic signed [GAP_W-1:0] gap_adj;
    logic                 passed;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_passed_reg, out_pulse_reg, out_day_reg, out_ms_reg};

    always_comb
    begin
        ms_sum     = {1'b0, ms_reg} + (MS_W + 1)'(step_reg);
        since_sum  = since_reg + SINCE_W'(step_reg);
        pulse      = 1'b0;
        ms_next    = ms_reg;
        day_next   = day_reg;
        since_next = since_reg;
        if (op_t'(op_reg) == OP_TICK)
        begin
            if (since_sum >= DECISEC_MS)
            begin
                since_next = '0;
                pulse      = 1'b1;
            end
            else
            begin
                since_next = since_sum;
            end
            if (ms_sum >= {1'b0, MS_PER_DAY})
            begin
                ms_next  = MS_W'(ms_sum - {1'b0, MS_PER_DAY});
                day_next = day_reg + DAY_W'(1);
            end
            else
            begin
                ms_next = ms_sum[MS_W-1:0];
            end
        end

        gap = $signed({2'b00, ms_reg}) - $signed({2'b00, start_reg});
        if (gap < 0)
        begin
            gap_adj = gap + $signed({2'b00, MS_PER_DAY});
        end
        else if (gap >= $signed({2'b00, MS_PER_DAY}))
        begin
            gap_adj = gap - $signed({2'b00, MS_PER_DAY});
        end
        else
        begin
            gap_adj = gap;
        end
        passed = (op_t'(op_reg) == OP_QUERY)
                 && (gap_adj >= $signed({(GAP_W - WAIT_W)'(0), wait_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ms_reg        <= '0;
            day_reg       <= '0;
            since_reg     <= '0;
            step_reg      <= MSEC_PER_TICK_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                step_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    ms_reg    <= ms_next;
                    day_reg   <= day_next;
                    since_reg <= since_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= s_tuser;
            start_reg <= s_tdata[MS_W-1:0];
            wait_reg  <= s_tdata[MS_W+WAIT_W-1:MS_W];
        end
        if (advance && in_valid_reg)
        begin
            out_ms_reg     <= ms_next;
            out_day_reg    <= day_next;
            out_pulse_reg  <= pulse;
            out_passed_reg <= passed;
        end
    end

endmodule

`default_nettype wire

// ===== src/ttod_checker.sv =====
// ============================================================================
// Tick time-of-day counter checker
// Port-level assertions for the tick time-of-day counter, bound to the top.
// ============================================================================
`default_nettype none

module ttod_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ttod_pkg::M_DATA_W-1:0] m_tdata
);

    import ttod_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Output word changed while stalled.");

    a_ms_in_day: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[MS_W-1:0] < MS_PER_DAY))
        else $error("Millisecond of day out of range.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[MS_W+DAY_W] && m_tdata[MS_W+DAY_W+1]))
        else $error("Pulse and passed flags set on the same word.");

    a_ready_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("Input not ready without an output stall.");

endmodule

bind tick_time_of_day_counter ttod_checker u_ttod_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
